// ===== rtl/ordered_list_insert_remove_top_defines.svh =====
// Assertion macros for the ordered list block and its checker.
// Include with the bare file name; no other dependencies.
`ifndef ORDERED_LIST_INSERT_REMOVE_TOP_DEFINES_SVH
`define ORDERED_LIST_INSERT_REMOVE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define OLIR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define OLIR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/olir_pkg.sv =====
// Shared types and constants for the ordered list block.
// No dependencies; used by the top level, the sequencer and the checker.
`timescale 1ns / 1ps
`default_nettype none

package olir_pkg;

  // Default store size and fixed field widths
  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned REQ_W        = 2;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned ENT_W        = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_EVENS  = 2'd3
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_LOOP,
    S_INS_MOVE,
    S_REM_LOOP,
    S_REM_MOVE,
    S_RD_ISSUE,
    S_RD_DATA,
    S_EV_LOOP,
    S_EV_CHK,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [STAT_W-1:0]       status;
    logic [ENT_W-1:0]        entries_in_use;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/ordered_list_insert_remove_top.sv =====
// Ordered list of signed 32-bit values held in a RAM of CAPACITY entries.
// Each input beat inserts, removes or reads at a position, or drops all odd
// entries, and gives one result beat. The list moves through a single RAM
// with one write and one registered read port, so every entry moved is
// read and then written back in a separate step. The block takes one
// request at a time; the output register lets the next request in while a
// result waits. No clearing pass after reset.
// Depends on olir_pkg, olir_seq, olir_step and olir_ram.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_insert_remove_top #(
  parameter int unsigned CAPACITY = olir_pkg::CAPACITY_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire olir_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output olir_pkg::out_t      out_data_o
);

  logic           res_valid, res_ready;
  olir_pkg::out_t res;
  logic           out_valid_q;
  olir_pkg::out_t out_data_q;

  olir_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Take a new result when the output register is empty or draining
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/olir_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module olir_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/olir_step.sv =====
// Shared index unit: increment, decrement and compare of one index pair.
// No dependencies; used by the sequencer for every loop step and range check.
`timescale 1ns / 1ps
`default_nettype none

module olir_step #(
  parameter int unsigned W = 5
) (
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  output logic      [W-1:0] inc_o,
  output logic      [W-1:0] dec_o,
  output logic              lt_o,
  output logic              eq_o
);

  // Step the index both ways and compare it against the bound
  assign inc_o = a_i + W'(1);
  assign dec_o = a_i - W'(1);
  assign lt_o  = (a_i < b_i);
  assign eq_o  = (a_i == b_i);

endmodule

`default_nettype wire

// ===== rtl/olir_seq.sv =====
// Request sequencer: range checks, entry moves through the RAM, result build.
// Depends on olir_pkg, olir_step and olir_ram.
`timescale 1ns / 1ps
`default_nettype none

module olir_seq #(
  parameter int unsigned CAPACITY = olir_pkg::CAPACITY_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire olir_pkg::in_t  in_data_i,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output olir_pkg::out_t      res_o
);

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = (CNT_W > olir_pkg::POS_W) ? CNT_W : olir_pkg::POS_W;
  localparam int unsigned VAL_W  = olir_pkg::VAL_W;
  localparam int unsigned POS_W  = olir_pkg::POS_W;
  localparam int unsigned ENT_W  = olir_pkg::ENT_W;

  olir_pkg::state_e  state_q, state_d;
  olir_pkg::status_e status_q, status_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  kept_q, kept_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic [VAL_W-1:0]  rdv_q, rdv_d;

  logic [CMP_W-1:0]  op_a, op_b, st_inc, st_dec;
  logic              st_lt, st_eq;
  logic [CMP_W-1:0]  pos_in_ext, pos_ext, cnt_ext, idx_ext, kept_ext;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [VAL_W-1:0]  ram_wdata, ram_rdata;

  assign pos_in_ext = CMP_W'(in_data_i.position);
  assign pos_ext    = CMP_W'(pos_q);
  assign cnt_ext    = CMP_W'(cnt_q);
  assign idx_ext    = CMP_W'(idx_q);
  assign kept_ext   = CMP_W'(kept_q);

  olir_step #(.W(CMP_W)) u_step (
    .a_i   (op_a),
    .b_i   (op_b),
    .inc_o (st_inc),
    .dec_o (st_dec),
    .lt_o  (st_lt),
    .eq_o  (st_eq)
  );

  olir_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // State and list registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= olir_pkg::S_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      kept_q   <= '0;
      status_q <= olir_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      kept_q   <= kept_d;
      status_q <= status_d;
    end
  end

  // Request payload holding registers
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    val_q <= val_d;
    rdv_q <= rdv_d;
  end

  // Next state, index unit operands and RAM control
  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    kept_d      = kept_q;
    pos_d       = pos_q;
    val_d       = val_q;
    rdv_d       = rdv_q;
    op_a        = idx_ext;
    op_b        = cnt_ext;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[ADDR_W-1:0];
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = idx_q[ADDR_W-1:0];
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      olir_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        // Insert checks count < position, remove and read position < count
        if (olir_pkg::req_e'(in_data_i.req_type) == olir_pkg::REQ_INSERT) begin
          op_a = cnt_ext;
          op_b = pos_in_ext;
        end else begin
          op_a = pos_in_ext;
          op_b = cnt_ext;
        end
        if (in_valid_i) begin
          pos_d    = in_data_i.position;
          val_d    = in_data_i.item_value;
          rdv_d    = '0;
          status_d = olir_pkg::ST_OK;
          unique case (olir_pkg::req_e'(in_data_i.req_type))
            olir_pkg::REQ_INSERT: begin
              if (st_lt) begin
                status_d = olir_pkg::ST_RANGE;
                state_d  = olir_pkg::S_RESP;
              end else if (cnt_q == CNT_W'(CAPACITY)) begin
                status_d = olir_pkg::ST_FULL;
                state_d  = olir_pkg::S_RESP;
              end else begin
                idx_d   = cnt_q;
                state_d = olir_pkg::S_INS_LOOP;
              end
            end
            olir_pkg::REQ_REMOVE: begin
              if (!st_lt) begin
                status_d = olir_pkg::ST_RANGE;
                state_d  = olir_pkg::S_RESP;
              end else begin
                idx_d   = st_inc[CNT_W-1:0];
                state_d = olir_pkg::S_REM_LOOP;
              end
            end
            olir_pkg::REQ_READ: begin
              if (!st_lt) begin
                status_d = olir_pkg::ST_RANGE;
                state_d  = olir_pkg::S_RESP;
              end else begin
                state_d = olir_pkg::S_RD_ISSUE;
              end
            end
            olir_pkg::REQ_EVENS: begin
              idx_d   = '0;
              kept_d  = '0;
              state_d = olir_pkg::S_EV_LOOP;
            end
          endcase
        end
      end

      // Shift entries up from the top down to the insert position
      olir_pkg::S_INS_LOOP: begin
        op_a = idx_ext;
        op_b = pos_ext;
        if (!st_lt && !st_eq) begin
          ram_re    = 1'b1;
          ram_raddr = st_dec[ADDR_W-1:0];
          state_d   = olir_pkg::S_INS_MOVE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pos_ext[ADDR_W-1:0];
          ram_wdata = val_q;
          cnt_d     = cnt_q + CNT_W'(1);
          state_d   = olir_pkg::S_RESP;
        end
      end

      olir_pkg::S_INS_MOVE: begin
        op_a      = idx_ext;
        ram_we    = 1'b1;
        ram_waddr = idx_q[ADDR_W-1:0];
        idx_d     = st_dec[CNT_W-1:0];
        state_d   = olir_pkg::S_INS_LOOP;
      end

      // Shift entries above the removed one down by one
      olir_pkg::S_REM_LOOP: begin
        op_a = idx_ext;
        op_b = cnt_ext;
        if (st_lt) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q[ADDR_W-1:0];
          state_d   = olir_pkg::S_REM_MOVE;
        end else begin
          cnt_d   = cnt_q - CNT_W'(1);
          state_d = olir_pkg::S_RESP;
        end
      end

      olir_pkg::S_REM_MOVE: begin
        op_a      = idx_ext;
        ram_we    = 1'b1;
        ram_waddr = st_dec[ADDR_W-1:0];
        idx_d     = st_inc[CNT_W-1:0];
        state_d   = olir_pkg::S_REM_LOOP;
      end

      olir_pkg::S_RD_ISSUE: begin
        ram_re    = 1'b1;
        ram_raddr = pos_ext[ADDR_W-1:0];
        state_d   = olir_pkg::S_RD_DATA;
      end

      olir_pkg::S_RD_DATA: begin
        rdv_d   = ram_rdata;
        state_d = olir_pkg::S_RESP;
      end

      // Walk the list, copying even entries down to the kept position
      olir_pkg::S_EV_LOOP: begin
        op_a = idx_ext;
        op_b = cnt_ext;
        if (st_lt) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q[ADDR_W-1:0];
          idx_d     = st_inc[CNT_W-1:0];
          state_d   = olir_pkg::S_EV_CHK;
        end else begin
          cnt_d   = kept_q;
          state_d = olir_pkg::S_RESP;
        end
      end

      olir_pkg::S_EV_CHK: begin
        op_a = kept_ext;
        if (!ram_rdata[0]) begin
          ram_we    = 1'b1;
          ram_waddr = kept_q[ADDR_W-1:0];
          kept_d    = st_inc[CNT_W-1:0];
        end
        state_d = olir_pkg::S_EV_LOOP;
      end

      olir_pkg::S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = olir_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = olir_pkg::S_IDLE;
      end
    endcase
  end

  // Result beat
  assign res_o.read_value     = rdv_q;
  assign res_o.status         = status_q;
  assign res_o.entries_in_use = cnt_ext[ENT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/olir_checker.sv =====
// Port-level checker for the ordered list block, bound to its top level.
// Depends on olir_pkg and ordered_list_insert_remove_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_list_insert_remove_top_defines.svh"

module olir_checker #(
  parameter int unsigned CAPACITY = olir_pkg::CAPACITY_DEF
) (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire olir_pkg::in_t  in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire olir_pkg::out_t out_data_o
);

  localparam int unsigned ENT_W = olir_pkg::ENT_W;
  localparam int unsigned IN_W  = $bits(olir_pkg::in_t);
  localparam int unsigned OUT_W = $bits(olir_pkg::out_t);
  localparam logic [ENT_W-1:0] CAP_ENT = ENT_W'(CAPACITY);

  logic           in_beat, in_wait, out_stall, full_res, at_cap, status_known;
  logic [IN_W:0]  in_word;
  logic [OUT_W:0] out_word;

  assign in_beat   = in_valid_i && in_ready_o;
  assign in_wait   = in_valid_i && !in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign full_res  = out_valid_o && (out_data_o.status == olir_pkg::ST_FULL);
  assign at_cap    = (out_data_o.entries_in_use == CAP_ENT);
  assign in_word   = {in_valid_i, in_data_i};
  assign out_word  = {out_valid_o, out_data_o};

  assign status_known = (out_data_o.status == olir_pkg::ST_OK)    ||
                        (out_data_o.status == olir_pkg::ST_RANGE) ||
                        (out_data_o.status == olir_pkg::ST_FULL);

  // A request keeps the block busy in the cycle after it is taken
  `OLIR_ASSERT_NXT(a_busy_after_beat, clk_i, rst_ni, in_beat, !in_ready_o, "ready after beat")

  // Status carries one of the three defined codes
  `OLIR_ASSERT_IMP(a_status_code, clk_i, rst_ni, out_valid_o, status_known, "bad status code")

  // A full-store rejection only happens with the store at capacity
  `OLIR_ASSERT_IMP(a_full_at_cap, clk_i, rst_ni, full_res, at_cap, "full status below capacity")

  // A stalled result beat stays put
  `OLIR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, $stable(out_word), "stalled result moved")

  // A waiting request beat stays put
  `OLIR_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_wait, $stable(in_word), "waiting request moved")

endmodule

bind ordered_list_insert_remove_top olir_checker #(.CAPACITY(CAPACITY)) u_olir_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
